// File: src/utf8ca_pkg.sv
// Package for the UTF-8 character assembler: status codes, sizes and lead-byte decode.
package utf8ca_pkg;

   localparam int unsigned MAX_CHAR_BYTES = 4;
   localparam int unsigned POS_W          = $clog2(MAX_CHAR_BYTES);
   localparam logic [6:0]  ASCII_FALLBACK = 7'h3F;

   // register index on the configuration port
   localparam logic REG_ENCODING_MODE = 1'b0;

   // encoding modes
   localparam logic MODE_ASCII = 1'b0;
   localparam logic MODE_UTF8  = 1'b1;

   typedef enum logic [1:0] {
      ST_INCOMPLETE = 2'd0,
      ST_COMPLETE   = 2'd1,
      ST_INVALID    = 2'd2
   } char_status_type;

   typedef logic [MAX_CHAR_BYTES-1:0][7:0] char_buf_type;

   // expected character length from the lead byte, 0 for a bad lead
   function automatic logic [2:0] lead_length(input logic [7:0] b);
      logic [2:0] len;
      len = 3'd0;
      if (b[7] == 1'b0) begin
         len = 3'd1;
      end else if (b[7:5] == 3'b110) begin
         len = 3'd2;
      end else if (b[7:4] == 4'b1110) begin
         len = 3'd3;
      end else if (b[7:3] == 5'b11110) begin
         len = 3'd4;
      end
      return len;
   endfunction

endpackage

// File: src/utf8_char_assembler.sv
// Top level of the UTF-8 / ASCII character assembler, one result word per input byte.
//
//   channel   direction  handshake            payload
//   req       in         req_valid/req_ready  req_data_byte
//   rsp       out        rsp_valid/rsp_ready  rsp_char_status, rsp_char_bytes, rsp_char_len,
//                                             rsp_is_terminator, rsp_ascii_byte
//   csr       in/out     psel/penable/pready  paddr, pwrite, pwdata, prdata
//
// A byte is taken per clock unless rsp stalls; its result is registered for the next cycle.
// The rate is set by the single output register: a byte is taken whenever that register
// is empty or is being drained in the same cycle.
// Reset (synchronous) sets UTF-8 mode, clears the byte position and empties the output.
// A stall on rsp holds the result and backs up into req_ready.
module utf8_char_assembler
   import utf8ca_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // input byte stream
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   // character results
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_char_status,
   output logic [31:0] rsp_char_bytes,
   output logic [2:0]  rsp_char_len,
   output logic        rsp_is_terminator,
   output logic [6:0]  rsp_ascii_byte,
   // configuration port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   // configuration and assembly state
   logic               mode_ff;
   logic [POS_W-1:0]   pos_ff,      pos_in;
   logic [2:0]         exp_len_ff,  exp_len_in;
   char_buf_type       char_buf_ff, char_buf_in;

   // output register
   logic               rsp_valid_ff;
   char_status_type    status_ff,   status_in;
   logic [31:0]        bytes_ff;
   logic [2:0]         len_ff;
   logic               term_ff,     term_in;
   logic [6:0]         ascii_ff,    ascii_in;

   logic               req_fire;
   logic               is_cont;
   logic [2:0]         pos_next;

   // config register access
   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_ENCODING_MODE) ? {31'd0, mode_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_UTF8;
      end else if (psel && penable && pwrite && pready && paddr[2] == REG_ENCODING_MODE) begin
         mode_ff <= pwdata[0];
      end
   end

   // take a byte when the output register is free or draining
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign is_cont   = (req_data_byte[7:6] == 2'b10);
   assign pos_next  = {1'b0, pos_ff} + 3'd1;

   // decode one byte against the current character
   always_comb begin
      char_buf_in = char_buf_ff;
      exp_len_in  = exp_len_ff;
      pos_in      = pos_ff;
      status_in   = ST_INCOMPLETE;
      if (mode_ff == MODE_ASCII) begin
         char_buf_in    = '0;
         char_buf_in[0] = req_data_byte;
         exp_len_in     = 3'd1;
         pos_in         = '0;
         status_in      = req_data_byte[7] ? ST_INVALID : ST_COMPLETE;
      end else if (pos_ff == '0) begin
         // lead byte: start a fresh character
         char_buf_in    = '0;
         char_buf_in[0] = req_data_byte;
         exp_len_in     = lead_length(req_data_byte);
         if (exp_len_in == 3'd0) begin
            status_in = ST_INVALID;
         end else if (exp_len_in == 3'd1) begin
            status_in = ST_COMPLETE;
         end else begin
            status_in = ST_INCOMPLETE;
         end
         pos_in = (status_in == ST_INCOMPLETE) ? POS_W'(1) : '0;
      end else if (!is_cont) begin
         // bad continuation: drop the byte, show what was stored
         status_in = ST_INVALID;
         pos_in    = '0;
      end else begin
         char_buf_in[pos_ff] = req_data_byte;
         if (exp_len_ff == pos_next) begin
            status_in = ST_COMPLETE;
            pos_in    = '0;
         end else begin
            status_in = ST_INCOMPLETE;
            pos_in    = pos_next[POS_W-1:0];
         end
      end
      term_in  = (exp_len_in == 3'd1) && (char_buf_in[0] == 8'd0);
      ascii_in = char_buf_in[0][7] ? ASCII_FALLBACK : char_buf_in[0][6:0];
   end

   // advance assembly state on each accepted byte
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         exp_len_ff <= 3'd0;
      end else if (req_fire) begin
         pos_ff     <= pos_in;
         exp_len_ff <= exp_len_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         char_buf_ff <= char_buf_in;
      end
   end

   // hold the result word until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         status_ff <= status_in;
         bytes_ff  <= char_buf_in;
         len_ff    <= exp_len_in;
         term_ff   <= term_in;
         ascii_ff  <= ascii_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_char_status   = status_ff;
   assign rsp_char_bytes    = bytes_ff;
   assign rsp_char_len      = len_ff;
   assign rsp_is_terminator = term_ff;
   assign rsp_ascii_byte    = ascii_ff;

   // a partial character is always shorter than its expected length
   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      (pos_ff != '0) |-> (exp_len_ff >= 3'd2 && {1'b0, pos_ff} < exp_len_ff))
      else $error("byte position outside the expected length");

   // ASCII mode never leaves a partial character behind
   a_ascii_restart: assert property (@(posedge clock) disable iff (reset)
      (req_fire && mode_ff == MODE_ASCII) |=> (pos_ff == '0))
      else $error("position not restarted after ASCII byte");

   // an incomplete word always belongs to a multi-byte character
   a_incomplete_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_ff == ST_INCOMPLETE) |-> (len_ff >= 3'd2))
      else $error("incomplete word with short length");

   // a complete word has a real length
   a_complete_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_ff == ST_COMPLETE) |-> (len_ff != 3'd0))
      else $error("complete word with zero length");

   // a word is only shown after a byte was taken
   a_rsp_from_req: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(req_fire))
      else $error("result word without accepted byte");

endmodule
